@@ rtl/plob_pkg.sv @@
// Shared types and constants for the price-level order book.
// Holds command codes, controller states and the controller/datapath signal groups.
// No dependencies.
package plob_pkg;

    // Item command codes.
    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_SNAPSHOT = 2'd1,
        CMD_DELTA    = 2'd2,
        CMD_QUERY    = 2'd3
    } command_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_GROUP,
        ST_PICK,
        ST_READ_BEST,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic update;
        logic group;
        logic pick;
        logic read_best;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
        logic out_valid;
    } dp_stat_t;

    // Best-level search works on groups of this many price levels.
    localparam int GROUP_SIZE  = 16;
    localparam int GROUP_IDX_W = 4;

    // Reported quantities are clipped to this width.
    localparam int OUT_QTY_W = 31;

    // Configuration port.
    localparam int          APB_ADDR_W      = 3;
    localparam logic        REG_SEL_BASE    = 1'b0;
    localparam logic [7:0]  BASE_RESET      = 8'd100;

endpackage

@@ rtl/plob_ctrl.sv @@
// Controller of the price-level order book: one state machine that sequences
// read-modify-write, the two-level best-level search and the result load.
// Depends on plob_pkg.
module plob_ctrl
    import plob_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_GROUP;
            end
            ST_GROUP:
            begin
                cmd.group  = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_READ_BEST;
            end
            ST_READ_BEST:
            begin
                cmd.read_best = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                // The result leaves once the output register is free; the next
                // item may be taken in the same cycle.
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    in_ready     = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/plob_dp.sv @@
// Datapath of the price-level order book: quantity memories, present marks,
// level update arithmetic, registered best-level search and the output register.
// Depends on plob_pkg; driven by plob_ctrl.
module plob_dp
    import plob_pkg::*;
#(
    parameter int PRICE_LEVELS = 128,
    parameter int QTY_BITS     = 31
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_stat_t                    stat,
    input  logic [7:0]                  complement_base,
    input  logic [1:0]                  command,
    input  logic                        side,
    input  logic [6:0]                  price,
    input  logic signed [31:0]          amount,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        bid_valid,
    output logic [6:0]                  bid_price,
    output logic [OUT_QTY_W-1:0]        bid_quantity,
    output logic                        ask_valid,
    output logic signed [8:0]           ask_price,
    output logic [OUT_QTY_W-1:0]        ask_quantity,
    output logic signed [8:0]           spread,
    output logic signed [9:0]           mid_doubled
);

    localparam int IDX_W  = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
    localparam int NGRP   = (PRICE_LEVELS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD    = NGRP * GROUP_SIZE;
    localparam int AW     = ((QTY_BITS > 32) ? QTY_BITS : 32) + 1;

    localparam logic [AW-1:0] QTY_MAX = {{(AW - QTY_BITS){1'b0}}, {QTY_BITS{1'b1}}};
    localparam logic [AW-1:0] OUT_MAX = {{(AW - OUT_QTY_W){1'b0}}, {OUT_QTY_W{1'b1}}};

    // Item registers.
    command_t          command_reg;
    logic              side_reg;
    logic [6:0]        price_reg;
    logic [31:0]       amount_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            command_reg <= command_t'(command);
            side_reg    <= side;
            price_reg   <= price;
            amount_reg  <= $unsigned(amount);
        end
    end

    // Quantity memories, one per side.
    logic [QTY_BITS-1:0] yes_mem [PRICE_LEVELS];
    logic [QTY_BITS-1:0] no_mem  [PRICE_LEVELS];
    logic [QTY_BITS-1:0] yes_rd_reg;
    logic [QTY_BITS-1:0] no_rd_reg;
    logic [IDX_W-1:0]    yes_addr;
    logic [IDX_W-1:0]    no_addr;
    logic [IDX_W-1:0]    bid_idx_reg;
    logic [IDX_W-1:0]    ask_idx_reg;
    logic [IDX_W-1:0]    wr_idx;
    logic [QTY_BITS-1:0] wr_qty;
    logic                qty_we;
    logic                pres_we;
    logic                new_pres;

    // The item's level is read on acceptance, the best levels after the search.
    assign yes_addr = cmd.load_item ? IDX_W'(price) : bid_idx_reg;
    assign no_addr  = cmd.load_item ? IDX_W'(price) : ask_idx_reg;
    assign wr_idx   = IDX_W'(price_reg);

    always_ff @(posedge clk)
    begin
        if (qty_we && !side_reg)
        begin
            yes_mem[wr_idx] <= wr_qty;
        end
        if (cmd.load_item || cmd.read_best)
        begin
            yes_rd_reg <= yes_mem[yes_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (qty_we && side_reg)
        begin
            no_mem[wr_idx] <= wr_qty;
        end
        if (cmd.load_item || cmd.read_best)
        begin
            no_rd_reg <= no_mem[no_addr];
        end
    end

    // Present marks.
    logic [PRICE_LEVELS-1:0] yes_pres_reg;
    logic [PRICE_LEVELS-1:0] no_pres_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yes_pres_reg <= '0;
            no_pres_reg  <= '0;
        end
        else if (cmd.update && command_reg == CMD_CLEAR)
        begin
            yes_pres_reg <= '0;
            no_pres_reg  <= '0;
        end
        else if (pres_we)
        begin
            if (side_reg)
            begin
                no_pres_reg[wr_idx] <= new_pres;
            end
            else
            begin
                yes_pres_reg[wr_idx] <= new_pres;
            end
        end
    end

    // Level update: snapshot overwrite or signed delta with saturation.
    logic            neg;
    logic [31:0]     mag32;
    logic [AW-1:0]   mag;
    logic [AW-1:0]   mag_sat;
    logic [AW-1:0]   cur_q;
    logic            cur_p;
    logic [AW-1:0]   sum;
    logic [AW-1:0]   sum_sat;
    logic [AW-1:0]   new_q;
    logic            in_range;
    logic            set_q;
    logic            set_p;

    always_comb
    begin
        neg      = amount_reg[31];
        mag32    = neg ? (~amount_reg + 32'd1) : amount_reg;
        mag      = AW'(mag32);
        mag_sat  = (mag > QTY_MAX) ? QTY_MAX : mag;
        cur_q    = AW'(side_reg ? no_rd_reg : yes_rd_reg);
        cur_p    = side_reg ? no_pres_reg[wr_idx] : yes_pres_reg[wr_idx];
        sum      = cur_q + mag;
        sum_sat  = (sum > QTY_MAX) ? QTY_MAX : sum;
        in_range = 32'(price_reg) < 32'(PRICE_LEVELS);
        new_q    = mag_sat;
        new_pres = 1'b0;
        set_q    = 1'b0;
        set_p    = 1'b0;
        case (command_reg)
            CMD_SNAPSHOT:
            begin
                set_p = 1'b1;
                if (!neg && mag != '0)
                begin
                    set_q    = 1'b1;
                    new_pres = 1'b1;
                end
            end
            CMD_DELTA:
            begin
                if (cur_p)
                begin
                    set_p = 1'b1;
                    if (neg)
                    begin
                        if (mag < cur_q)
                        begin
                            set_q    = 1'b1;
                            new_q    = cur_q - mag;
                            new_pres = 1'b1;
                        end
                    end
                    else
                    begin
                        set_q    = 1'b1;
                        new_q    = sum_sat;
                        new_pres = (sum_sat != '0);
                    end
                end
                else if (!neg && mag != '0)
                begin
                    set_p    = 1'b1;
                    set_q    = 1'b1;
                    new_pres = 1'b1;
                end
            end
            default:
            begin
                set_q = 1'b0;
                set_p = 1'b0;
            end
        endcase
        qty_we  = cmd.update && in_range && set_q;
        pres_we = cmd.update && in_range && set_p;
        wr_qty  = QTY_BITS'(new_q);
    end

    // Search, first level: highest present level inside each group.
    logic [PAD-1:0]         yes_pad;
    logic [PAD-1:0]         no_pad;
    logic                   yes_any_reg [NGRP];
    logic                   no_any_reg  [NGRP];
    logic [GROUP_IDX_W-1:0] yes_lo_reg  [NGRP];
    logic [GROUP_IDX_W-1:0] no_lo_reg   [NGRP];
    logic                   yes_any     [NGRP];
    logic                   no_any      [NGRP];
    logic [GROUP_IDX_W-1:0] yes_lo      [NGRP];
    logic [GROUP_IDX_W-1:0] no_lo       [NGRP];

    assign yes_pad = PAD'(yes_pres_reg);
    assign no_pad  = PAD'(no_pres_reg);

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            yes_any[g] = |yes_pad[g*GROUP_SIZE +: GROUP_SIZE];
            no_any[g]  = |no_pad[g*GROUP_SIZE +: GROUP_SIZE];
            yes_lo[g]  = '0;
            no_lo[g]   = '0;
            for (int b = 0; b < GROUP_SIZE; b++)
            begin
                if (yes_pad[g*GROUP_SIZE + b])
                begin
                    yes_lo[g] = GROUP_IDX_W'(b);
                end
                if (no_pad[g*GROUP_SIZE + b])
                begin
                    no_lo[g] = GROUP_IDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.group)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                yes_any_reg[g] <= yes_any[g];
                no_any_reg[g]  <= no_any[g];
                yes_lo_reg[g]  <= yes_lo[g];
                no_lo_reg[g]   <= no_lo[g];
            end
        end
    end

    // Search, second level: highest group that holds a level.
    logic                          bid_found;
    logic                          ask_found;
    logic [GSEL_W+GROUP_IDX_W-1:0] bid_full;
    logic [GSEL_W+GROUP_IDX_W-1:0] ask_full;
    logic                          bid_found_reg;
    logic                          ask_found_reg;

    always_comb
    begin
        bid_found = 1'b0;
        ask_found = 1'b0;
        bid_full  = '0;
        ask_full  = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (yes_any_reg[g])
            begin
                bid_found = 1'b1;
                bid_full  = {GSEL_W'(g), yes_lo_reg[g]};
            end
            if (no_any_reg[g])
            begin
                ask_found = 1'b1;
                ask_full  = {GSEL_W'(g), no_lo_reg[g]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_found_reg <= 1'b0;
            ask_found_reg <= 1'b0;
        end
        else if (cmd.pick)
        begin
            bid_found_reg <= bid_found;
            ask_found_reg <= ask_found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            bid_idx_reg <= IDX_W'(bid_full);
            ask_idx_reg <= IDX_W'(ask_full);
        end
    end

    // Result arithmetic from the best levels and their quantities.
    logic [AW-1:0]        bid_q_wide;
    logic [AW-1:0]        ask_q_wide;
    logic [OUT_QTY_W-1:0] bid_q_out;
    logic [OUT_QTY_W-1:0] ask_q_out;
    logic [11:0]          bid12;
    logic [11:0]          ask12;
    logic                 both;

    always_comb
    begin
        bid_q_wide = AW'(yes_rd_reg);
        ask_q_wide = AW'(no_rd_reg);
        bid_q_out  = (bid_q_wide > OUT_MAX) ? OUT_QTY_W'(OUT_MAX) : OUT_QTY_W'(bid_q_wide);
        ask_q_out  = (ask_q_wide > OUT_MAX) ? OUT_QTY_W'(OUT_MAX) : OUT_QTY_W'(ask_q_wide);
        bid12      = 12'(bid_idx_reg);
        ask12      = 12'(complement_base) - 12'(ask_idx_reg);
        both       = bid_found_reg && ask_found_reg;
    end

    // Output register.
    logic                 out_valid_reg;
    logic                 bid_valid_reg;
    logic [6:0]           bid_price_reg;
    logic [OUT_QTY_W-1:0] bid_quantity_reg;
    logic                 ask_valid_reg;
    logic signed [8:0]    ask_price_reg;
    logic [OUT_QTY_W-1:0] ask_quantity_reg;
    logic signed [8:0]    spread_reg;
    logic signed [9:0]    mid_doubled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            bid_valid_reg    <= bid_found_reg;
            bid_price_reg    <= bid_found_reg ? 7'(bid_idx_reg) : 7'd0;
            bid_quantity_reg <= bid_found_reg ? bid_q_out : '0;
            ask_valid_reg    <= ask_found_reg;
            ask_price_reg    <= ask_found_reg ? $signed(9'(ask12)) : 9'sd0;
            ask_quantity_reg <= ask_found_reg ? ask_q_out : '0;
            spread_reg       <= both ? $signed(9'(ask12 - bid12)) : 9'sd0;
            mid_doubled_reg  <= both ? $signed(10'(ask12 + bid12)) : 10'sd0;
        end
    end

    assign stat.out_busy  = out_valid_reg && !out_ready;
    assign stat.out_valid = out_valid_reg;

    assign out_valid    = out_valid_reg;
    assign bid_valid    = bid_valid_reg;
    assign bid_price    = bid_price_reg;
    assign bid_quantity = bid_quantity_reg;
    assign ask_valid    = ask_valid_reg;
    assign ask_price    = ask_price_reg;
    assign ask_quantity = ask_quantity_reg;
    assign spread       = spread_reg;
    assign mid_doubled  = mid_doubled_reg;

endmodule

@@ rtl/price_level_order_book_top.sv @@
// Price-level order book for a two-sided binary market.
//
// Input channel (in_valid/in_ready) carries one item: command, side, price and
// a signed amount. Commands clear the book, load a snapshot level, apply a
// delta, or only query. Every item yields exactly one result item on the
// output channel (out_valid/out_ready): best bid, best ask, their quantities,
// spread and doubled mid price. Fields of an empty side read as zero, and
// spread and mid read as zero unless both sides hold a level.
//
// After an item is accepted, the block steps through the read-modify-write
// of the quantity memory, the two registered levels of the best-level search
// and the read of the best quantities through the same memory port, then
// loads the output register; it takes no new item before that result is loaded.
// While the receiver stalls, a finished result waits in the output register
// and the block holds the next result until that register is free.
// Reset empties both sides (present marks cleared at once) and sets
// complement_base to 100; no clearing pass is needed.
// complement_base is written over the APB port at byte address 0.
// Depends on plob_pkg, plob_ctrl and plob_dp.
module price_level_order_book_top
    import plob_pkg::*;
#(
    parameter int PRICE_LEVELS = 128,
    parameter int QTY_BITS     = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Input channel.
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    input  logic                   side,
    input  logic [6:0]             price,
    input  logic signed [31:0]     amount,
    // Output channel.
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   bid_valid,
    output logic [6:0]             bid_price,
    output logic [OUT_QTY_W-1:0]   bid_quantity,
    output logic                   ask_valid,
    output logic signed [8:0]      ask_price,
    output logic [OUT_QTY_W-1:0]   ask_quantity,
    output logic signed [8:0]      spread,
    output logic signed [9:0]      mid_doubled
);

    // Configuration register.
    logic [7:0] complement_base_reg;
    logic       base_hit;

    assign pready   = 1'b1;
    assign base_hit = (paddr[2] == REG_SEL_BASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complement_base_reg <= BASE_RESET;
        end
        else if (psel && penable && pwrite && base_hit)
        begin
            complement_base_reg <= pwdata[7:0];
        end
    end

    assign prdata = base_hit ? {24'd0, complement_base_reg} : 32'd0;

    // Controller and datapath.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    plob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plob_dp #(
        .PRICE_LEVELS (PRICE_LEVELS),
        .QTY_BITS     (QTY_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .complement_base (complement_base_reg),
        .command         (command),
        .side            (side),
        .price           (price),
        .amount          (amount),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .bid_valid       (bid_valid),
        .bid_price       (bid_price),
        .bid_quantity    (bid_quantity),
        .ask_valid       (ask_valid),
        .ask_price       (ask_price),
        .ask_quantity    (ask_quantity),
        .spread          (spread),
        .mid_doubled     (mid_doubled)
    );

    // An accepted item keeps the input closed while it is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while an item is in progress");

    // A result is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !stat.out_busy)
        else $error("result loaded over a stalled result");

    // An empty yes side reports zeros for bid, spread and mid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bid_valid |-> bid_price == 7'd0 && bid_quantity == '0
            && spread == 9'sd0 && mid_doubled == 10'sd0)
        else $error("empty bid side with nonzero fields");

    // An empty no side reports zeros for ask, spread and mid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ask_valid |-> ask_price == 9'sd0 && ask_quantity == '0
            && spread == 9'sd0 && mid_doubled == 10'sd0)
        else $error("empty ask side with nonzero fields");

endmodule

@@ bench/price_level_order_book_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the price-level order book: book updates go in, each
// result item is checked against a level-by-level model of both sides.
// Depends on plob_pkg and price_level_order_book_top.
module price_level_order_book_top_tb;
    import plob_pkg::*;

    localparam int          LEVELS       = 128;
    localparam logic [32:0] QTY_LIMIT    = 33'h0_7FFF_FFFF;
    localparam int          CYCLE_LIMIT  = 200_000;
    localparam int          HOLD_AT      = 400;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CALM_FROM    = 900;
    localparam int          CALM_TO      = 1150;
    localparam int          BURST_ITEMS  = 310;

    // One book update as it goes into the block.
    typedef struct {
        command_t           command;
        logic               side;
        logic [6:0]         price;
        logic [31:0]        amount;
    } order_item_t;

    // Top-of-book view that comes back for every item.
    typedef struct {
        logic               bid_valid;
        logic [6:0]         bid_price;
        logic [30:0]        bid_quantity;
        logic               ask_valid;
        logic signed [8:0]  ask_price;
        logic [30:0]        ask_quantity;
        logic signed [8:0]  spread;
        logic signed [9:0]  mid_doubled;
    } book_view_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             command = '0;
    logic                   side = 1'b0;
    logic [6:0]             price = '0;
    logic signed [31:0]     amount = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   bid_valid;
    logic [6:0]             bid_price;
    logic [OUT_QTY_W-1:0]   bid_quantity;
    logic                   ask_valid;
    logic signed [8:0]      ask_price;
    logic [OUT_QTY_W-1:0]   ask_quantity;
    logic signed [8:0]      spread;
    logic signed [9:0]      mid_doubled;

    // Model state: quantity and present mark per side and price.
    logic [30:0]            level_qty [2][LEVELS];
    bit                     level_live [2][LEVELS];
    logic [7:0]             book_base = BASE_RESET;

    order_item_t            pending_orders [$];
    book_view_t             book_views_due [$];
    int                     orders_accepted = 0;
    int                     views_checked = 0;
    int                     mismatch_count = 0;
    int                     cycle_count = 0;
    int                     hold_left = 0;
    bit                     hold_done = 1'b0;
    logic                   hold_active = 1'b0;

    price_level_order_book_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .side         (side),
        .price        (price),
        .amount       (amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bid_valid    (bid_valid),
        .bid_price    (bid_price),
        .bid_quantity (bid_quantity),
        .ask_valid    (ask_valid),
        .ask_price    (ask_price),
        .ask_quantity (ask_quantity),
        .spread       (spread),
        .mid_doubled  (mid_doubled)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one item to the model book and returns the view it produces.
    function automatic book_view_t apply_order(input order_item_t ord);
        book_view_t  view;
        bit          neg;
        logic [32:0] mag;
        logic [32:0] total;
        int          best [2];
        bit          found [2];
        int          ask;
        int          gap;
        int          mid;
        neg = ord.amount[31];
        mag = neg ? (33'h1_0000_0000 - {1'b0, ord.amount}) : {1'b0, ord.amount};
        case (ord.command)
            CMD_CLEAR:
            begin
                for (int p = 0; p < LEVELS; p++)
                begin
                    level_live[0][p] = 1'b0;
                    level_live[1][p] = 1'b0;
                end
            end
            CMD_SNAPSHOT:
            begin
                // A snapshot overwrites the level; a non-positive amount leaves it absent.
                if (neg || mag == 0)
                    level_live[ord.side][ord.price] = 1'b0;
                else
                begin
                    level_qty[ord.side][ord.price] = (mag > QTY_LIMIT) ? QTY_LIMIT[30:0] : mag[30:0];
                    level_live[ord.side][ord.price] = 1'b1;
                end
            end
            CMD_DELTA:
            begin
                if (level_live[ord.side][ord.price])
                begin
                    if (neg)
                    begin
                        if (mag >= {2'b00, level_qty[ord.side][ord.price]})
                            level_live[ord.side][ord.price] = 1'b0;
                        else
                            level_qty[ord.side][ord.price] -= mag[30:0];
                    end
                    else
                    begin
                        total = {2'b00, level_qty[ord.side][ord.price]} + mag;
                        level_qty[ord.side][ord.price] =
                            (total > QTY_LIMIT) ? QTY_LIMIT[30:0] : total[30:0];
                        if (level_qty[ord.side][ord.price] == 0)
                            level_live[ord.side][ord.price] = 1'b0;
                    end
                end
                else if (!neg && mag != 0)
                begin
                    // An absent level is only created by a positive change.
                    level_qty[ord.side][ord.price] = (mag > QTY_LIMIT) ? QTY_LIMIT[30:0] : mag[30:0];
                    level_live[ord.side][ord.price] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Best level of each side is its highest present price.
        for (int s = 0; s < 2; s++)
        begin
            found[s] = 1'b0;
            best[s] = 0;
            for (int p = LEVELS - 1; p >= 0; p--)
            begin
                if (!found[s] && level_live[s][p])
                begin
                    found[s] = 1'b1;
                    best[s] = p;
                end
            end
        end

        view = '{default: '0};
        if (found[0])
        begin
            view.bid_valid = 1'b1;
            view.bid_price = best[0][6:0];
            view.bid_quantity = level_qty[0][best[0]];
        end
        if (found[1])
        begin
            ask = int'(book_base) - best[1];
            view.ask_valid = 1'b1;
            view.ask_price = ask[8:0];
            view.ask_quantity = level_qty[1][best[1]];
        end
        if (found[0] && found[1])
        begin
            gap = ask - best[0];
            mid = ask + best[0];
            view.spread = gap[8:0];
            view.mid_doubled = mid[9:0];
        end
        return view;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    function automatic bit in_calm_stretch(input int count);
        return count >= CALM_FROM && count < CALM_TO;
    endfunction

    // Sender side: offers pending items, holding each until it is taken.
    always @(posedge clk)
    begin : drive_orders
        order_item_t next_order;
        order_item_t accepted_order;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted_order.command = command_t'(command);
                accepted_order.side = side;
                accepted_order.price = price;
                accepted_order.amount = amount;
                book_views_due.push_back(apply_order(accepted_order));
                orders_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_orders.size() != 0 &&
                    (in_calm_stretch(orders_accepted) || $urandom_range(99) >= 30))
                begin
                    next_order = pending_orders.pop_front();
                    command <= next_order.command;
                    side <= next_order.side;
                    price <= next_order.price;
                    amount <= next_order.amount;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off so the block backs up and stalls its input.
    always @(posedge clk)
    begin : hold_off
        if (!rst_n)
        begin
            hold_left = 0;
            hold_active <= 1'b0;
        end
        else
        begin
            if (!hold_done && views_checked >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hold_active <= 1'b1;
            end
            else
            begin
                hold_active <= 1'b0;
            end
        end
    end

    // Receiver side: checks each result item and stalls at random.
    always @(posedge clk)
    begin : check_views
        book_view_t want;
        bit         stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (book_views_due.size() == 0)
                begin
                    $display("%0t ns: result item with no expected item waiting", $time);
                    mismatch_count++;
                end
                else
                begin
                    want = book_views_due.pop_front();
                    check_field("bid_valid", want.bid_valid, bid_valid);
                    check_field("bid_price", want.bid_price, bid_price);
                    check_field("bid_quantity", want.bid_quantity, bid_quantity);
                    check_field("ask_valid", want.ask_valid, ask_valid);
                    check_field("ask_price", want.ask_price, ask_price);
                    check_field("ask_quantity", want.ask_quantity, ask_quantity);
                    check_field("spread", want.spread, spread);
                    check_field("mid_doubled", want.mid_doubled, mid_doubled);
                end
                views_checked++;
            end

            if (hold_active)
                stall = 1'b1;
            else if (in_calm_stretch(views_checked))
                stall = 1'b0;
            else
                stall = $urandom_range(99) < 30;
            out_ready <= !stall;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_register(input logic [APB_ADDR_W-1:0] addr, output logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_order(input command_t c, input logic s, input logic [6:0] p,
                             input logic [31:0] a);
        order_item_t ord;
        ord.command = c;
        ord.side = s;
        ord.price = p;
        ord.amount = a;
        pending_orders.push_back(ord);
    endtask

    // Blocks until every item has been taken and every result has come back.
    task automatic wait_until_idle();
        do @(negedge clk);
        while (pending_orders.size() != 0 || in_valid || book_views_due.size() != 0);
    endtask

    // Mostly small realistic sizes, with zero, saturation and sign extremes mixed in.
    function automatic logic [31:0] pick_amount(input bit want_positive);
        int r;
        r = $urandom_range(99);
        if (want_positive && r < 60)
            return $urandom_range(500, 1);
        if (r < 35)
            return $urandom_range(300, 1);
        if (r < 60)
            return 32'd0 - $urandom_range(300, 1);
        if (r < 68)
            return 32'd0;
        if (r < 78)
            return 32'h7FFF_FFFF - $urandom_range(255, 0);
        if (r < 84)
            return 32'h8000_0000 + $urandom_range(3, 0);
        return $urandom;
    endfunction

    // Prices cluster in a band so updates keep hitting live levels; the no band
    // mirrors the yes band through the complement.
    function automatic logic [6:0] pick_price(input int hot, input logic s);
        int center;
        center = s ? ((int'(book_base) - hot - 12) & 127) : hot;
        if ($urandom_range(99) < 70)
            return 7'((center + $urandom_range(11, 0)) & 127);
        return 7'($urandom_range(127, 0));
    endfunction

    // Snapshots, deltas and queries with the occasional full resync and noise.
    task automatic queue_market_burst(input int count, input int hot);
        int   made;
        int   r;
        int   levels;
        logic s;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(99);
            s = 1'($urandom_range(1, 0));
            if (r < 5)
            begin
                add_order(CMD_CLEAR, 1'($urandom_range(1, 0)), 7'($urandom_range(127, 0)),
                          $urandom);
                levels = $urandom_range(8, 2);
                for (int k = 0; k < levels; k++)
                begin
                    s = 1'($urandom_range(1, 0));
                    add_order(CMD_SNAPSHOT, s, pick_price(hot, s), pick_amount(1'b1));
                end
                made += levels + 1;
            end
            else
            begin
                if (r < 25)
                    add_order(CMD_SNAPSHOT, s, pick_price(hot, s), pick_amount(1'b1));
                else if (r < 80)
                    add_order(CMD_DELTA, s, pick_price(hot, s), pick_amount(1'b0));
                else if (r < 90)
                    add_order(CMD_QUERY, s, 7'($urandom_range(127, 0)), $urandom);
                else
                    add_order(command_t'($urandom_range(3, 0)), s, 7'($urandom_range(127, 0)),
                              $urandom);
                made++;
            end
        end
    endtask

    // Reset, directed corner cases, then random bursts under several bases.
    initial
    begin : run_phases
        logic [7:0]  base_plan [4];
        logic [31:0] readback;
        base_plan[0] = 8'd255;
        base_plan[1] = 8'd0;
        base_plan[2] = 8'($urandom_range(255, 0));
        base_plan[3] = 8'd37;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_register({REG_SEL_BASE, 2'b00}, readback);
        check_field("complement_base", {24'd0, book_base}, readback);

        // Empty book, single sides, overwrite and saturation.
        add_order(CMD_QUERY,    1'b0, 7'd0,   32'd0);
        add_order(CMD_SNAPSHOT, 1'b0, 7'd0,   32'd1);
        add_order(CMD_SNAPSHOT, 1'b1, 7'd127, 32'h7FFF_FFFF);
        add_order(CMD_SNAPSHOT, 1'b0, 7'd127, 32'd5);
        add_order(CMD_SNAPSHOT, 1'b0, 7'd127, 32'd9);
        add_order(CMD_DELTA,    1'b0, 7'd127, 32'h7FFF_FFFF);
        add_order(CMD_DELTA,    1'b1, 7'd127, 32'd1);
        // Removal by a large negative delta and by a non-positive snapshot.
        add_order(CMD_DELTA,    1'b0, 7'd127, 32'h8000_0000);
        add_order(CMD_SNAPSHOT, 1'b0, 7'd0,   32'hFFFF_FFFD);
        // A delta at an absent level inserts only when positive.
        add_order(CMD_DELTA,    1'b0, 7'd50,  32'hFFFF_FFF6);
        add_order(CMD_DELTA,    1'b0, 7'd50,  32'd0);
        add_order(CMD_DELTA,    1'b0, 7'd50,  32'd20);
        add_order(CMD_DELTA,    1'b0, 7'd50,  32'hFFFF_FFFB);
        add_order(CMD_DELTA,    1'b0, 7'd50,  32'hFFFF_FFF1);
        add_order(CMD_SNAPSHOT, 1'b0, 7'd64,  32'h8000_0000);
        add_order(CMD_SNAPSHOT, 1'b0, 7'd64,  32'd0);
        // Both sides live, ask below zero and a negative spread.
        add_order(CMD_SNAPSHOT, 1'b1, 7'd0,   32'd7);
        add_order(CMD_SNAPSHOT, 1'b0, 7'd100, 32'd3);
        add_order(CMD_DELTA,    1'b1, 7'd127, 32'hFFFF_FFFF);
        add_order(CMD_QUERY,    1'b1, 7'd127, 32'hFFFF_FFFF);
        add_order(CMD_CLEAR,    1'b1, 7'd99,  32'h1234_5678);
        add_order(CMD_QUERY,    1'b0, 7'd0,   32'd0);
        queue_market_burst(BURST_ITEMS - 10, $urandom_range(127, 0));

        foreach (base_plan[i])
        begin
            wait_until_idle();
            write_register({REG_SEL_BASE, 2'b00}, {24'd0, base_plan[i]});
            book_base = base_plan[i];
            read_register({REG_SEL_BASE, 2'b00}, readback);
            check_field("complement_base", {24'd0, book_base}, readback);
            queue_market_burst(BURST_ITEMS, $urandom_range(127, 0));
        end

        wait_until_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
